FILE: rtl/e2c_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2c_pkg: shared constants for the epoch to calendar converter
// Time bases, summer-time windows, reciprocal constants for the divide
// stages and the month-start table of one four-year cycle.
// ----------------------------------------------------------------------------
package e2c_pkg;

    // Field widths
    localparam int EPOCH_W = 32;
    localparam int SEC_W   = 6;
    localparam int MIN_W   = 6;
    localparam int HOUR_W  = 5;
    localparam int DAY_W   = 5;
    localparam int MON_W   = 4;
    localparam int YEAR_W  = 7;

    // Time bases in seconds since 1970
    localparam logic [EPOCH_W-1:0] BASE_2000  = 32'd946684800;
    localparam logic [EPOCH_W-1:0] END_2099   = 32'd4102444800;
    localparam logic [EPOCH_W-1:0] DST_OFFSET = 32'd3600;

    // Open intervals of Dutch summer time
    localparam int SUMMER_N = 7;
    localparam logic [EPOCH_W-1:0] SUMMER_START [SUMMER_N] = '{
        32'd1459040400, 32'd1490490000, 32'd1521939600, 32'd1553994000,
        32'd1585443600, 32'd1616893200, 32'd1648342800
    };
    localparam logic [EPOCH_W-1:0] SUMMER_END [SUMMER_N] = '{
        32'd1477792800, 32'd1509242400, 32'd1540692000, 32'd1572141600,
        32'd1603591200, 32'd1635645600, 32'd1667095200
    };

    // Reciprocals: q = (n * MAGIC) >> SHIFT, exact over the ranges used here
    localparam logic [31:0] DIV60_MAGIC   = 32'h8888_8889;  // shift 37, n < 2^32
    localparam int          DIV60_SHIFT   = 37;
    localparam logic [23:0] DIV24_MAGIC   = 24'd11184811;   // shift 28, n < 2^20
    localparam int          DIV24_SHIFT   = 28;
    localparam logic [15:0] DIV1461_MAGIC = 16'd45934;      // shift 26, n < 2^16
    localparam int          DIV1461_SHIFT = 26;

    localparam logic [10:0] CYCLE_DAYS = 11'd1461;

    // Day number of each month start within a four-year span that opens on a leap year
    localparam int YEARS_N  = 4;
    localparam int MONTHS_N = 12;
    localparam logic [10:0] MONTH_START [YEARS_N][MONTHS_N] = '{
        '{11'd0,    11'd31,   11'd60,   11'd91,   11'd121,  11'd152,
          11'd182,  11'd213,  11'd244,  11'd274,  11'd305,  11'd335},
        '{11'd366,  11'd397,  11'd425,  11'd456,  11'd486,  11'd517,
          11'd547,  11'd578,  11'd609,  11'd639,  11'd670,  11'd700},
        '{11'd731,  11'd762,  11'd790,  11'd821,  11'd851,  11'd882,
          11'd912,  11'd943,  11'd974,  11'd1004, 11'd1035, 11'd1065},
        '{11'd1096, 11'd1127, 11'd1155, 11'd1186, 11'd1216, 11'd1247,
          11'd1277, 11'd1308, 11'd1339, 11'd1369, 11'd1400, 11'd1430}
    };

endpackage

FILE: rtl/epoch_to_calendar_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_to_calendar_top: Unix timestamp to calendar date and time
// Nine-stage pipeline: optional summer-time hour, range check against
// 2000..2099, reciprocal divides by 60, 60, 24 and 1461, then a lookup of
// year and month within the four-year cycle.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+-------------------------------
//   input    | in        | start & !busy        | i_epoch
//   result   | out       | o_done (one cycle)   | o_second .. o_valid_res
//   config   | in        | i_dst_enable_we      | i_dst_enable
//
// One transaction per cycle; o_done rises when a taken transaction has passed
// through the register stages A, B, C, D, E, F, G, H and O in that order.
// busy stays low: the receiver cannot stall, so nothing holds the pipeline.
// Reset (synchronous, active low) clears the stage valid bits and sets
// dst_enable to 0; no clearing pass is needed.
// ----------------------------------------------------------------------------
module epoch_to_calendar_top
    import e2c_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [EPOCH_W-1:0]  i_epoch,
    input  logic                i_dst_enable_we,
    input  logic                i_dst_enable,
    output logic                o_done,
    output logic [SEC_W-1:0]    o_second,
    output logic [MIN_W-1:0]    o_minute,
    output logic [HOUR_W-1:0]   o_hour,
    output logic [DAY_W-1:0]    o_day,
    output logic [MON_W-1:0]    o_month,
    output logic [YEAR_W-1:0]   o_year_offset,
    output logic                o_valid_res
);

    // Configuration
    logic                r_dst_enable;

    // Stage registers
    logic                r_a_vld, r_b_vld, r_c_vld, r_d_vld, r_e_vld;
    logic                r_f_vld, r_g_vld, r_h_vld, r_o_vld;
    logic [EPOCH_W-1:0]  r_a_epoch;
    logic                r_a_dst;
    logic [EPOCH_W-1:0]  r_b_t;
    logic                r_c_ok, r_d_ok, r_e_ok, r_f_ok, r_g_ok, r_h_ok;
    logic [EPOCH_W-1:0]  r_c_rel, r_d_rel;
    logic [25:0]         r_d_q1, r_e_q1;
    logic [19:0]         r_e_q2, r_f_q2;
    logic [15:0]         r_f_q3, r_g_q3;
    logic [4:0]          r_g_cyc, r_h_cyc;
    logic [SEC_W-1:0]    r_e_sec, r_f_sec, r_g_sec, r_h_sec;
    logic [MIN_W-1:0]    r_f_min, r_g_min, r_h_min;
    logic [HOUR_W-1:0]   r_g_hour, r_h_hour;
    logic [10:0]         r_h_rem;
    logic [1:0]          r_h_yr;
    logic [SEC_W-1:0]    r_o_sec;
    logic [MIN_W-1:0]    r_o_min;
    logic [HOUR_W-1:0]   r_o_hour;
    logic [DAY_W-1:0]    r_o_day;
    logic [MON_W-1:0]    r_o_mon;
    logic [YEAR_W-1:0]   r_o_year;
    logic                r_o_ok;

    // Next values
    logic                n_accept;
    logic                n_summer;
    logic [EPOCH_W-1:0]  n_t;
    logic                n_ok;
    logic [EPOCH_W-1:0]  n_rel;
    logic [63:0]         n_prod1;
    logic [57:0]         n_prod2;
    logic [43:0]         n_prod3;
    logic [31:0]         n_prod4;
    logic [EPOCH_W-1:0]  n_sec_full;
    logic [25:0]         n_min_full;
    logic [19:0]         n_hour_full;
    logic [15:0]         n_rem_full;
    logic [10:0]         n_rem;
    logic [1:0]          n_yr;
    logic [MON_W-1:0]    n_mon;
    logic [10:0]         n_day_full;
    logic [YEAR_W-1:0]   n_year;

    assign busy     = 1'b0;
    assign n_accept = start & ~busy;

    // Hold the summer-time enable
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dst_enable <= 1'b0;
        end else if (i_dst_enable_we) begin
            r_dst_enable <= i_dst_enable;
        end
    end

    // Stage B: summer-time window test and hour offset
    always_comb begin
        n_summer = 1'b0;
        for (int k = 0; k < SUMMER_N; k++) begin
            if (r_a_epoch > SUMMER_START[k] && r_a_epoch < SUMMER_END[k]) begin
                n_summer = 1'b1;
            end
        end
        n_t = (r_a_dst && n_summer) ? r_a_epoch + DST_OFFSET : r_a_epoch;
    end

    // Stage C: range check and rebase to 2000
    assign n_ok  = (r_b_t >= BASE_2000) && (r_b_t < END_2099);
    assign n_rel = r_b_t - BASE_2000;

    // Stage D: total minutes
    assign n_prod1 = 64'(r_c_rel) * 64'(DIV60_MAGIC);

    // Stage E: seconds and total hours
    assign n_sec_full = r_d_rel - (32'(r_d_q1) * 32'd60);
    assign n_prod2    = 58'(r_d_q1) * 58'(DIV60_MAGIC);

    // Stage F: minutes and total days
    assign n_min_full = r_e_q1 - (26'(r_e_q2) * 26'd60);
    assign n_prod3    = 44'(r_e_q2) * 44'(DIV24_MAGIC);

    // Stage G: hours and four-year cycles
    assign n_hour_full = r_f_q2 - (20'(r_f_q3) * 20'd24);
    assign n_prod4     = 32'(r_f_q3) * 32'(DIV1461_MAGIC);

    // Stage H: day within cycle and year within cycle
    always_comb begin
        n_rem_full = r_g_q3 - (16'(r_g_cyc) * 16'(CYCLE_DAYS));
        n_rem      = n_rem_full[10:0];
        if (n_rem >= MONTH_START[3][0]) begin
            n_yr = 2'd3;
        end else if (n_rem >= MONTH_START[2][0]) begin
            n_yr = 2'd2;
        end else if (n_rem >= MONTH_START[1][0]) begin
            n_yr = 2'd1;
        end else begin
            n_yr = 2'd0;
        end
    end

    // Stage O: month, day and year; zero the fields out of range
    always_comb begin
        n_mon = '0;
        for (int k = 1; k < MONTHS_N; k++) begin
            if (r_h_rem >= MONTH_START[r_h_yr][k]) begin
                n_mon = MON_W'(k);
            end
        end
        n_day_full = r_h_rem - MONTH_START[r_h_yr][n_mon] + 11'd1;
        n_year     = {r_h_cyc, 2'b00} + YEAR_W'(r_h_yr);
    end

    // Advance the valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
            r_g_vld <= 1'b0;
            r_h_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            r_a_vld <= n_accept;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
            r_e_vld <= r_d_vld;
            r_f_vld <= r_e_vld;
            r_g_vld <= r_f_vld;
            r_h_vld <= r_g_vld;
            r_o_vld <= r_h_vld;
        end
    end

    // Advance the payload
    always_ff @(posedge i_clk) begin
        r_a_epoch <= i_epoch;
        r_a_dst   <= r_dst_enable;

        r_b_t     <= n_t;

        r_c_ok    <= n_ok;
        r_c_rel   <= n_rel;

        r_d_ok    <= r_c_ok;
        r_d_rel   <= r_c_rel;
        r_d_q1    <= n_prod1[DIV60_SHIFT+25:DIV60_SHIFT];

        r_e_ok    <= r_d_ok;
        r_e_sec   <= n_sec_full[SEC_W-1:0];
        r_e_q1    <= r_d_q1;
        r_e_q2    <= n_prod2[DIV60_SHIFT+19:DIV60_SHIFT];

        r_f_ok    <= r_e_ok;
        r_f_sec   <= r_e_sec;
        r_f_min   <= n_min_full[MIN_W-1:0];
        r_f_q2    <= r_e_q2;
        r_f_q3    <= n_prod3[DIV24_SHIFT+15:DIV24_SHIFT];

        r_g_ok    <= r_f_ok;
        r_g_sec   <= r_f_sec;
        r_g_min   <= r_f_min;
        r_g_hour  <= n_hour_full[HOUR_W-1:0];
        r_g_q3    <= r_f_q3;
        r_g_cyc   <= n_prod4[DIV1461_SHIFT+4:DIV1461_SHIFT];

        r_h_ok    <= r_g_ok;
        r_h_sec   <= r_g_sec;
        r_h_min   <= r_g_min;
        r_h_hour  <= r_g_hour;
        r_h_cyc   <= r_g_cyc;
        r_h_rem   <= n_rem;
        r_h_yr    <= n_yr;

        r_o_ok    <= r_h_ok;
        r_o_sec   <= r_h_ok ? r_h_sec : '0;
        r_o_min   <= r_h_ok ? r_h_min : '0;
        r_o_hour  <= r_h_ok ? r_h_hour : '0;
        r_o_day   <= r_h_ok ? n_day_full[DAY_W-1:0] : '0;
        r_o_mon   <= r_h_ok ? n_mon + 4'd1 : '0;
        r_o_year  <= r_h_ok ? n_year : '0;
    end

    // Drive the result ports
    assign o_done        = r_o_vld;
    assign o_second      = r_o_sec;
    assign o_minute      = r_o_min;
    assign o_hour        = r_o_hour;
    assign o_day         = r_o_day;
    assign o_month       = r_o_mon;
    assign o_year_offset = r_o_year;
    assign o_valid_res   = r_o_ok;

endmodule
